### sv/thresholded_top_k_per_column_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the top-k per column block and its port checker
// ---------------------------------------------------------------------------
`ifndef THRESHOLDED_TOP_K_PER_COLUMN_ASSERT_SVH
`define THRESHOLDED_TOP_K_PER_COLUMN_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define TKPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tkpc assertion failed");

// condition holds in the cycle after the trigger
`define TKPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tkpc assertion failed");

`endif

### sv/tkpc_pkg.sv
// ---------------------------------------------------------------------------
// tkpc_pkg
// shared sizes, entry and control types for the top-k per column block
// ---------------------------------------------------------------------------
`default_nettype none

package tkpc_pkg;

  localparam int MAX_KEEP   = 16;
  localparam int ROW_BITS   = 16;
  localparam int VALUE_BITS = 32;

  localparam int KEEP_BITS = 5;   // width of the keep_count register
  localparam int RANK_BITS = 5;
  localparam int COL_BITS  = 16;
  localparam int CFG_BITS  = VALUE_BITS;

  localparam int IDX_BITS = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_BITS = (KEEP_BITS > IDX_BITS + 1) ? KEEP_BITS : IDX_BITS + 1;

  typedef enum logic [1:0] {
    REG_KEEP_COUNT   = 2'd0,
    REG_MIN_VALUE    = 2'd1,
    REG_OFFSET       = 2'd2,
    REG_RANK_BY_MAG  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] score;
    logic signed [VALUE_BITS-1:0] value;
    logic        [ROW_BITS-1:0]   row;
  } entry_t;

  typedef struct packed {
    logic attempt;  // a scored entry is offered to the chain
    logic pop;      // shift the chain one place toward the head
    logic clear;    // drop every kept entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/thresholded_top_k_per_column.sv
// ---------------------------------------------------------------------------
// thresholded_top_k_per_column
// streaming top-k selection per matrix column with offset and threshold
// ---------------------------------------------------------------------------
// Values enter one per cycle, column by column. A front stage adds the
// offset with saturation, applies the minimum threshold and forms the score
// (signed value or saturated magnitude); the next cycle the entry is placed
// into a chain of MAX_KEEP compare-and-shift cells in a single step. Inside a
// column the block therefore takes one beat per cycle. The beat that ends a
// column holds off input until its ranking is out: it passes the front stage,
// then k output beats are shifted from the head of the chain, one per cycle
// while the output side does not stall. After the last rank the chain is
// cleared and the column counter advances.
// ---------------------------------------------------------------------------
`default_nettype none

module thresholded_top_k_per_column (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_index_i,
  input  logic [tkpc_pkg::CFG_BITS-1:0]          cfg_data_i,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [tkpc_pkg::VALUE_BITS-1:0] sample_i,
  input  logic                                   is_missing_i,
  input  logic [tkpc_pkg::ROW_BITS-1:0]          row_index_i,
  input  logic                                   column_end_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [tkpc_pkg::COL_BITS-1:0]          column_index_o,
  output logic [tkpc_pkg::RANK_BITS-1:0]         rank_o,
  output logic [tkpc_pkg::ROW_BITS-1:0]          winner_row_o,
  output logic signed [tkpc_pkg::VALUE_BITS-1:0] winner_value_o,
  output logic                                   is_empty_o,
  output logic                                   last_of_column_o
);
  import tkpc_pkg::*;

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_e;

  // configuration registers
  logic [KEEP_BITS-1:0]         keep_count_q;
  logic signed [VALUE_BITS-1:0] min_value_q;
  logic signed [VALUE_BITS-1:0] offset_q;
  logic                         rank_by_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q  <= KEEP_BITS'(16);
      min_value_q   <= VAL_MIN;
      offset_q      <= '0;
      rank_by_mag_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KEEP_COUNT:  keep_count_q  <= cfg_data_i[KEEP_BITS-1:0];
        REG_MIN_VALUE:   min_value_q   <= cfg_data_i[VALUE_BITS-1:0];
        REG_OFFSET:      offset_q      <= cfg_data_i[VALUE_BITS-1:0];
        REG_RANK_BY_MAG: rank_by_mag_q <= cfg_data_i[0];
      endcase
    end
  end

  // effective keep count, clamped to 1..MAX_KEEP
  logic [CNT_BITS-1:0] keep_eff;
  always_comb begin
    priority if (keep_count_q == '0) begin
      keep_eff = CNT_BITS'(1);
    end else if (CNT_BITS'(keep_count_q) > CNT_BITS'(MAX_KEEP)) begin
      keep_eff = CNT_BITS'(MAX_KEEP);
    end else begin
      keep_eff = CNT_BITS'(keep_count_q);
    end
  end

  // front stage: saturating offset, threshold, score
  logic                         in_accept;
  logic signed [VALUE_BITS:0]   sum_wide;
  logic signed [VALUE_BITS-1:0] off_val;
  logic signed [VALUE_BITS-1:0] mag_val;
  logic                         passes;
  entry_t                       front_entry;

  assign in_accept = in_valid_i && !in_stall_o;
  assign sum_wide  = {sample_i[VALUE_BITS-1], sample_i} + {offset_q[VALUE_BITS-1], offset_q};

  always_comb begin
    if (sum_wide[VALUE_BITS] != sum_wide[VALUE_BITS-1]) begin
      off_val = sum_wide[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end else begin
      off_val = sum_wide[VALUE_BITS-1:0];
    end
    if (!off_val[VALUE_BITS-1]) begin
      mag_val = off_val;
    end else if (off_val == VAL_MIN) begin
      mag_val = VAL_MAX;
    end else begin
      mag_val = -off_val;
    end
    passes            = !is_missing_i && !(off_val < min_value_q);
    front_entry.score = rank_by_mag_q ? mag_val : off_val;
    front_entry.value = off_val;
    front_entry.row   = row_index_i;
  end

  logic   s1_valid_q;
  logic   s1_attempt_q;
  logic   s1_col_end_q;
  entry_t s1_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_attempt_q <= 1'b0;
      s1_col_end_q <= 1'b0;
    end else begin
      s1_valid_q   <= in_accept;
      s1_attempt_q <= in_accept && passes;
      s1_col_end_q <= in_accept && column_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_entry_q <= front_entry;
    end
  end

  // sorted chain
  state_e              state_q;
  logic [CNT_BITS-1:0] rank_q;
  logic [COL_BITS-1:0] col_cnt_q;
  logic                out_valid_q;
  logic                pop;
  logic                last_rank;
  cell_ctrl_t          ctrl;
  entry_t              head_entry;
  logic                head_full;

  assign pop       = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall_i);
  assign last_rank = (CNT_BITS'(rank_q + CNT_BITS'(1)) == keep_eff);

  assign ctrl.attempt = s1_valid_q && s1_attempt_q;
  assign ctrl.pop     = pop;
  assign ctrl.clear   = pop && last_rank;

  tkpc_chain u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .keep_i       (keep_eff),
    .new_entry_i  (s1_entry_q),
    .head_entry_o (head_entry),
    .head_full_o  (head_full)
  );

  // no new beat while a column end is in flight or its ranking drains
  assign in_stall_o = (state_q == ST_DRAIN) || (s1_valid_q && s1_col_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_RUN;
      rank_q           <= '0;
      col_cnt_q        <= '0;
      out_valid_q      <= 1'b0;
      column_index_o   <= '0;
      rank_o           <= '0;
      winner_row_o     <= '0;
      winner_value_o   <= '0;
      is_empty_o       <= 1'b0;
      last_of_column_o <= 1'b0;
    end else begin
      out_valid_q <= pop || (out_valid_q && out_stall_i);
      if (pop) begin
        column_index_o   <= col_cnt_q;
        rank_o           <= RANK_BITS'(rank_q + CNT_BITS'(1));
        winner_row_o     <= head_full ? head_entry.row : '0;
        winner_value_o   <= head_full ? head_entry.value : '0;
        is_empty_o       <= !head_full;
        last_of_column_o <= last_rank;
      end
      unique case (state_q)
        ST_RUN: begin
          if (s1_valid_q && s1_col_end_q) begin
            state_q <= ST_DRAIN;
            rank_q  <= '0;
          end
        end
        ST_DRAIN: begin
          if (pop) begin
            rank_q <= CNT_BITS'(rank_q + CNT_BITS'(1));
            if (last_rank) begin
              state_q   <= ST_RUN;
              col_cnt_q <= COL_BITS'(col_cnt_q + COL_BITS'(1));
            end
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### sv/tkpc_cell.sv
// ---------------------------------------------------------------------------
// tkpc_cell
// one slot of the sorted chain: compares the offered entry against its own,
// takes the offer or its left neighbor on insert, its right neighbor on pop
// ---------------------------------------------------------------------------
`default_nettype none

module tkpc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tkpc_pkg::cell_ctrl_t ctrl_i,
  input  logic                ins_ok_i,
  input  logic                active_i,
  input  tkpc_pkg::entry_t    new_entry_i,
  input  logic                prev_beats_i,
  input  tkpc_pkg::entry_t    left_entry_i,
  input  logic                left_full_i,
  input  tkpc_pkg::entry_t    right_entry_i,
  input  logic                right_full_i,
  output logic                beats_o,
  output tkpc_pkg::entry_t    entry_o,
  output logic                full_o
);
  import tkpc_pkg::*;

  entry_t entry_q, entry_d;
  logic   full_q, full_d;

  // offered entry ranks ahead of this slot
  assign beats_o = !full_q ||
                   ($signed(new_entry_i.score) > $signed(entry_q.score)) ||
                   (($signed(new_entry_i.score) == $signed(entry_q.score)) &&
                    (new_entry_i.row < entry_q.row));

  always_comb begin
    full_d  = full_q;
    entry_d = entry_q;
    priority if (ctrl_i.clear) begin
      full_d = 1'b0;
    end else if (ctrl_i.pop) begin
      full_d  = right_full_i;
      entry_d = right_entry_i;
    end else if (ctrl_i.attempt) begin
      if (!active_i) begin
        full_d = 1'b0;
      end else if (ins_ok_i && beats_o) begin
        if (prev_beats_i) begin
          full_d  = left_full_i;
          entry_d = left_entry_i;
        end else begin
          full_d  = 1'b1;
          entry_d = new_entry_i;
        end
      end
    end else begin
      full_d  = full_q;
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign full_o  = full_q;

endmodule

`default_nettype wire

### sv/tkpc_chain.sv
// ---------------------------------------------------------------------------
// tkpc_chain
// row of compare-and-shift cells holding the kept entries in rank order,
// head cell is rank 1
// ---------------------------------------------------------------------------
`default_nettype none

module tkpc_chain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tkpc_pkg::cell_ctrl_t          ctrl_i,
  input  logic [tkpc_pkg::CNT_BITS-1:0] keep_i,
  input  tkpc_pkg::entry_t              new_entry_i,
  output tkpc_pkg::entry_t              head_entry_o,
  output logic                          head_full_o
);
  import tkpc_pkg::*;

  entry_t              entry_w [MAX_KEEP];
  logic [MAX_KEEP-1:0] full_w;
  logic [MAX_KEEP-1:0] beats_w;
  logic [MAX_KEEP-1:0] active_w;
  logic [IDX_BITS-1:0] last_idx;
  logic                ins_ok;

  // when the kept set is full the offer must strictly beat the lowest score
  assign last_idx = IDX_BITS'(keep_i - CNT_BITS'(1));
  assign ins_ok   = !full_w[last_idx] ||
                    ($signed(new_entry_i.score) > $signed(entry_w[last_idx].score));

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_full, right_full, prev_beats;

    assign active_w[i] = (int'(keep_i) > i);

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_full  = 1'b0;
      assign prev_beats = 1'b0;
    end else begin : g_body
      assign left_entry = entry_w[i-1];
      assign left_full  = full_w[i-1];
      assign prev_beats = beats_w[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign right_entry = '0;
      assign right_full  = 1'b0;
    end else begin : g_mid
      assign right_entry = entry_w[i+1];
      assign right_full  = full_w[i+1];
    end

    tkpc_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .ins_ok_i      (ins_ok),
      .active_i      (active_w[i]),
      .new_entry_i   (new_entry_i),
      .prev_beats_i  (prev_beats),
      .left_entry_i  (left_entry),
      .left_full_i   (left_full),
      .right_entry_i (right_entry),
      .right_full_i  (right_full),
      .beats_o       (beats_w[i]),
      .entry_o       (entry_w[i]),
      .full_o        (full_w[i])
    );
  end

  assign head_entry_o = entry_w[0];
  assign head_full_o  = full_w[0];

endmodule

`default_nettype wire

### sv/tkpc_checker.sv
// ---------------------------------------------------------------------------
// tkpc_checker
// port-level checks on the ranking output of the top-k per column block
// ---------------------------------------------------------------------------
`default_nettype none

`include "thresholded_top_k_per_column_assert.svh"

module tkpc_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_stall_o,
  input  logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  input  logic [tkpc_pkg::COL_BITS-1:0]          column_index_o,
  input  logic [tkpc_pkg::RANK_BITS-1:0]         rank_o,
  input  logic [tkpc_pkg::ROW_BITS-1:0]          winner_row_o,
  input  logic signed [tkpc_pkg::VALUE_BITS-1:0] winner_value_o,
  input  logic                                   is_empty_o,
  input  logic                                   last_of_column_o
);

  logic out_beat;
  assign out_beat = out_valid_o && !out_stall_i;

  // a stalled result beat holds
  `TKPC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(rank_o) && $stable(winner_row_o) && $stable(winner_value_o))

  // input waits while a ranking is still being delivered
  `TKPC_ASSERT_NOW(a_stall_in_drain, out_valid_o && !last_of_column_o, in_stall_o)

  // ranks of one column follow back to back with the same column index
  `TKPC_ASSERT_NEXT(a_rank_step, out_beat && !last_of_column_o,
    out_valid_o && (rank_o == $past(rank_o) + 1'b1) &&
    (column_index_o == $past(column_index_o)))

  // once a rank is empty every later rank of the column is empty
  `TKPC_ASSERT_NEXT(a_empty_tail, out_beat && is_empty_o && !last_of_column_o,
    is_empty_o && (winner_row_o == '0) && (winner_value_o == '0))

endmodule

bind thresholded_top_k_per_column tkpc_checker u_tkpc_checker (.*);

`default_nettype wire
